// ===== rtl/afd_pkg.sv =====
package afd_pkg;

    localparam int DIM_BITS       = 13;
    localparam int POS_BITS       = 12;
    localparam int NUM_BITS       = 13;
    localparam int MAX_DIMENSION  = 4096;
    localparam int PIXEL_BYTES    = 4;
    localparam int PIXEL_BITS     = PIXEL_BYTES * 8;
    localparam int PROD_BITS      = 2 * DIM_BITS;
    localparam int DIV_BITS       = PROD_BITS;
    localparam int DEN_BITS       = DIM_BITS + 1;
    localparam int CNT_BITS       = $clog2(DIV_BITS + 1);
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HEIGHT = 2'd3;

    localparam logic [DIM_BITS-1:0] DIM_MAX = DIM_BITS'(MAX_DIMENSION);
    localparam logic [DIM_BITS-1:0] DIM_ONE = DIM_BITS'(1);

    typedef struct packed {
        logic                scaling_active;
        logic [DIM_BITS-1:0] fitted_width;
        logic [DIM_BITS-1:0] fitted_height;
    } fit_t;

    typedef struct packed {
        logic emit;
        logic row_end;
        logic frame_end;
    } flags_t;

    // limit to the supported range, zero optionally raised to one
    function automatic logic [DIM_BITS-1:0] clamp_dim(
        input logic [DIM_BITS-1:0] v,
        input logic                at_least_one
    );
        logic [DIM_BITS-1:0] r;
        r = v;
        if (at_least_one && (v == '0))
        begin
            r = DIM_ONE;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/aspect_fit_nearest_downscaler.sv =====
// channel   direction   handshake              payload
// in        sink        in_valid / in_ready    pixel_in, frame_start
// out       source      out_valid / out_ready  pixel_out, row_end, frame_end
// cfg       sink        cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a word without frame_start skips the fit; such words stream at one per cycle unless the output stalls
// a word with frame_start holds off the input while the size fit runs, with no division
// when no scaling is needed, else with the 26-step restoring divider
// that is run once or twice for the fit
// asynchronous active-low reset; no clearing pass, the block is ready right after reset
// a stalled output word holds its register; the input is taken only if that slot frees
module aspect_fit_nearest_downscaler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [afd_pkg::PIXEL_BITS-1:0]      pixel_in,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [afd_pkg::PIXEL_BITS-1:0]      pixel_out,
    output logic                                row_end,
    output logic                                frame_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [afd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [afd_pkg::DIM_BITS-1:0]        cfg_data
);
    import afd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FIT  = 2'd1;
    localparam logic [1:0] S_PROC = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [DIM_BITS-1:0]   src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
    logic [PIXEL_BITS-1:0] hold_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [PIXEL_BITS-1:0] pixel_reg;
    logic                  row_end_reg, frame_end_reg;
    logic [DIM_BITS-1:0]   w, h, tw, th;
    logic                  slot_free;
    logic                  accept;
    logic                  fit_start, fit_done;
    logic                  step;
    logic [PIXEL_BITS-1:0] step_pixel;
    fit_t                  fit;
    flags_t                flags;

    assign w  = clamp_dim(src_w_reg, 1'b1);
    assign h  = clamp_dim(src_h_reg, 1'b1);
    assign tw = clamp_dim(tgt_w_reg, 1'b0);
    assign th = clamp_dim(tgt_h_reg, 1'b0);

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign fit_start  = accept && frame_start;
    assign step       = (accept && !frame_start) || ((state_reg == S_PROC) && slot_free);
    assign step_pixel = (state_reg == S_PROC) ? hold_reg : pixel_in;

    afd_fit u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fit_start),
        .width      (w),
        .height     (h),
        .box_width  (tw),
        .box_height (th),
        .done       (fit_done),
        .fit        (fit)
    );

    afd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .clear  (fit_start),
        .width  (w),
        .height (h),
        .fit    (fit),
        .flags  (flags)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fit_start)
                begin
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                if (fit_done)
                begin
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && flags.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            src_w_reg     <= DIM_ONE;
            src_h_reg     <= DIM_ONE;
            tgt_w_reg     <= '0;
            tgt_h_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  src_w_reg <= cfg_data;
                    REG_SOURCE_HEIGHT: src_h_reg <= cfg_data;
                    REG_TARGET_WIDTH:  tgt_w_reg <= cfg_data;
                    REG_TARGET_HEIGHT: tgt_h_reg <= cfg_data;
                    default:           src_w_reg <= src_w_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fit_start)
        begin
            hold_reg <= pixel_in;
        end
        if (step && flags.emit)
        begin
            pixel_reg     <= step_pixel;
            row_end_reg   <= flags.row_end;
            frame_end_reg <= flags.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// ===== rtl/afd_div.sv =====
module afd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [afd_pkg::DIV_BITS-1:0]  dividend,
    input  logic [afd_pkg::DEN_BITS-1:0]  divisor,
    output logic                          done,
    output logic [afd_pkg::DIV_BITS-1:0]  quotient
);
    import afd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                ge;

    // one restoring step per cycle
    assign trial = {rem_reg, num_reg[DIV_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIV_BITS);
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DIV_BITS-2:0], ge};
            rem_next = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== rtl/afd_fit.sv =====
module afd_fit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [afd_pkg::DIM_BITS-1:0]  width,
    input  logic [afd_pkg::DIM_BITS-1:0]  height,
    input  logic [afd_pkg::DIM_BITS-1:0]  box_width,
    input  logic [afd_pkg::DIM_BITS-1:0]  box_height,
    output logic                          done,
    output afd_pkg::fit_t                 fit
);
    import afd_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV1 = 2'd1;
    localparam logic [1:0] F_DIV2 = 2'd2;
    localparam logic [1:0] F_DONE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic                 done_reg, done_next;
    fit_t                 fit_reg, fit_next;
    logic [DIM_BITS-1:0]  ow_reg, ow_next;
    logic [DIM_BITS-1:0]  oh_reg, oh_next;
    logic                 bypass;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_BITS-1:0]  quotient;
    logic                 second;
    logic [DIM_BITS-1:0]  mul_a, mul_b, den_base;
    logic [PROD_BITS-1:0] product;
    logic [DIV_BITS-1:0]  dividend;
    logic [DEN_BITS-1:0]  divisor;
    logic                 q_over_box;
    logic                 q_over_width;

    assign bypass = (box_width == '0) || (box_height == '0)
                    || ((width <= box_width) && (height <= box_height));

    // round(a*b/base) = (2*a*b + base) / (2*base)
    assign second   = (state_reg == F_DIV1);
    assign mul_a    = second ? box_height : box_width;
    assign mul_b    = second ? width : height;
    assign den_base = second ? height : width;
    assign product  = mul_a * mul_b;
    assign dividend = {product[PROD_BITS-2:0], 1'b0} + {{(DIV_BITS-DIM_BITS){1'b0}}, den_base};
    assign divisor  = {den_base, 1'b0};

    assign q_over_box   = quotient > {{(DIV_BITS-DIM_BITS){1'b0}}, box_height};
    assign q_over_width = quotient > {{(DIV_BITS-DIM_BITS){1'b0}}, width};

    afd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        fit_next   = fit_reg;
        ow_next    = ow_reg;
        oh_next    = oh_reg;
        div_start  = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    if (bypass)
                    begin
                        fit_next.scaling_active = 1'b0;
                        fit_next.fitted_width   = width;
                        fit_next.fitted_height  = height;
                        done_next               = 1'b1;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = F_DIV1;
                    end
                end
            end
            F_DIV1:
            begin
                if (div_done)
                begin
                    if (q_over_box)
                    begin
                        oh_next    = box_height;
                        div_start  = 1'b1;
                        state_next = F_DIV2;
                    end
                    else
                    begin
                        ow_next    = box_width;
                        oh_next    = quotient[DIM_BITS-1:0];
                        state_next = F_DONE;
                    end
                end
            end
            F_DIV2:
            begin
                if (div_done)
                begin
                    ow_next    = q_over_width ? width : quotient[DIM_BITS-1:0];
                    state_next = F_DONE;
                end
            end
            F_DONE:
            begin
                fit_next.scaling_active = 1'b1;
                fit_next.fitted_width   = (ow_reg == '0) ? DIM_ONE
                                        : ((ow_reg > width) ? width : ow_reg);
                fit_next.fitted_height  = (oh_reg == '0) ? DIM_ONE
                                        : ((oh_reg > height) ? height : oh_reg);
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            fit_reg   <= '{scaling_active: 1'b0, fitted_width: DIM_ONE, fitted_height: DIM_ONE};
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fit_reg   <= fit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
        oh_reg <= oh_next;
    end

    assign done = done_reg;
    assign fit  = fit_reg;

endmodule

// ===== rtl/afd_scan.sv =====
module afd_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          clear,
    input  logic [afd_pkg::DIM_BITS-1:0]  width,
    input  logic [afd_pkg::DIM_BITS-1:0]  height,
    input  afd_pkg::fit_t                 fit,
    output afd_pkg::flags_t               flags
);
    import afd_pkg::*;

    logic [POS_BITS-1:0] sc_reg, sc_next;
    logic [POS_BITS-1:0] sr_reg, sr_next;
    logic [DIM_BITS-1:0] oc_reg, oc_next;
    logic [DIM_BITS-1:0] or_reg, or_next;
    logic [NUM_BITS-1:0] cn_reg, cn_next;
    logic [NUM_BITS-1:0] rn_reg, rn_next;
    logic                last_col, last_row;
    logic                col_sel, row_sel;
    logic                scaled_row_end;
    logic [NUM_BITS:0]   cn_sum, rn_sum;
    logic [NUM_BITS-1:0] cn_upd, rn_upd;

    assign last_col = ({1'b0, sc_reg} + DIM_BITS'(1)) >= width;
    assign last_row = ({1'b0, sr_reg} + DIM_BITS'(1)) >= height;

    assign col_sel = (oc_reg < fit.fitted_width) && (cn_reg < fit.fitted_width);
    assign row_sel = (or_reg < fit.fitted_height) && (rn_reg < fit.fitted_height);

    assign scaled_row_end = col_sel && ((oc_reg + DIM_BITS'(1)) == fit.fitted_width);

    always_comb
    begin
        if (fit.scaling_active)
        begin
            flags.emit      = row_sel && col_sel;
            flags.row_end   = scaled_row_end;
            flags.frame_end = scaled_row_end
                              && ((or_reg + DIM_BITS'(1)) == fit.fitted_height);
        end
        else
        begin
            flags.emit      = 1'b1;
            flags.row_end   = last_col;
            flags.frame_end = last_col && last_row;
        end
    end

    // remainder tracking of floor(x*W/fw) against the source column
    assign cn_sum = col_sel ? ({1'b0, cn_reg} + {1'b0, width}) : {1'b0, cn_reg};
    assign rn_sum = row_sel ? ({1'b0, rn_reg} + {1'b0, height}) : {1'b0, rn_reg};
    always_comb
    begin
        cn_upd = '0;
        rn_upd = '0;
        if (cn_sum >= {1'b0, fit.fitted_width})
        begin
            cn_upd = NUM_BITS'(cn_sum - {1'b0, fit.fitted_width});
        end
        if (rn_sum >= {1'b0, fit.fitted_height})
        begin
            rn_upd = NUM_BITS'(rn_sum - {1'b0, fit.fitted_height});
        end
    end

    always_comb
    begin
        sc_next = sc_reg;
        sr_next = sr_reg;
        oc_next = oc_reg;
        or_next = or_reg;
        cn_next = cn_reg;
        rn_next = rn_reg;
        if (clear)
        begin
            sc_next = '0;
            sr_next = '0;
            oc_next = '0;
            or_next = '0;
            cn_next = '0;
            rn_next = '0;
        end
        else if (step)
        begin
            if (fit.scaling_active)
            begin
                cn_next = cn_upd;
                oc_next = oc_reg + DIM_BITS'(col_sel);
                if (last_col)
                begin
                    rn_next = rn_upd;
                    or_next = or_reg + DIM_BITS'(row_sel);
                end
            end
            if (last_col)
            begin
                sc_next = '0;
                oc_next = '0;
                cn_next = '0;
                if (last_row)
                begin
                    sr_next = '0;
                    or_next = '0;
                    rn_next = '0;
                end
                else
                begin
                    sr_next = sr_reg + POS_BITS'(1);
                end
            end
            else
            begin
                sc_next = sc_reg + POS_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg <= '0;
            sr_reg <= '0;
            oc_reg <= '0;
            or_reg <= '0;
            cn_reg <= '0;
            rn_reg <= '0;
        end
        else
        begin
            sc_reg <= sc_next;
            sr_reg <= sr_next;
            oc_reg <= oc_next;
            or_reg <= or_next;
            cn_reg <= cn_next;
            rn_reg <= rn_next;
        end
    end

endmodule

// ===== rtl/afd_chk.sv =====
module afd_chk (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [afd_pkg::PIXEL_BITS-1:0]      pixel_in,
    input  logic                                frame_start,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [afd_pkg::PIXEL_BITS-1:0]      pixel_out,
    input  logic                                row_end,
    input  logic                                frame_end,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [afd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [afd_pkg::DIM_BITS-1:0]        cfg_data
);

    // a stalled output word stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(row_end) && $stable(frame_end))
        else $error("output word changed while stalled");

    // the last word of a thumbnail always closes a row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    // a frame start word holds off the input for the size fit
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && frame_start |=> !in_ready)
        else $error("input taken during size fit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind aspect_fit_nearest_downscaler afd_chk u_afd_chk (.*);
